/* sv/mss_pkg.sv */
// Shared constants, microcode word layout and control program for the sensor smoother.
package mss_pkg;

  // Field widths of the channels
  localparam int IN_MUX_W    = 2;
  localparam int IN_CHAN_W   = 3;
  localparam int IN_SAMPLE_W = 10;
  localparam int OUT_VALUE_W = 10;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int MODE_W     = 2;
  localparam int BTN_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_MASK = 1'b1;

  // Smoothing modes; the spare code behaves as passthrough
  localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRIM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HALF = 2'd2;

  // History window. The datapath drops exactly the smallest and largest entry,
  // which is what these bounds give for a 13-deep window.
  localparam int WINDOW    = 13;
  localparam int TRIM_LO   = (WINDOW * 15 / 100 < 1) ? 1 : WINDOW * 15 / 100;
  localparam int TRIM_HI   = (WINDOW * 85 / 100 + 1 > WINDOW - 1) ? WINDOW - 1
                                                                  : WINDOW * 85 / 100 + 1;
  localparam int TRIM_CNT  = TRIM_HI - TRIM_LO;
  localparam int SLOT_W    = $clog2(WINDOW);
  localparam int PTR_W     = $clog2(WINDOW + 1);

  // Divide by TRIM_CNT as multiply by rounded-up reciprocal; exact below 2^15
  localparam int DIV_SHIFT = 17;
  localparam int DIV_MUL   = (2 ** DIV_SHIFT + TRIM_CNT - 1) / TRIM_CNT;
  localparam int DIV_MUL_W = $clog2(DIV_MUL + 1);

  // Microcode
  localparam int UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_FETCH    = 3'd0;
  localparam upc_t UPC_DISPATCH = 3'd1;
  localparam upc_t UPC_WRITE    = 3'd2;
  localparam upc_t UPC_READ     = 3'd3;
  localparam upc_t UPC_TRIM     = 3'd4;
  localparam upc_t UPC_MUL      = 3'd5;
  localparam upc_t UPC_SCALE    = 3'd6;
  localparam upc_t UPC_OUT      = 3'd7;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_t;

  typedef enum logic [1:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_SIMPLE,
    JMP_MORE
  } jmp_t;

  typedef struct packed {
    logic  in_take;
    logic  simple_ld;
    logic  hist_wr;
    logic  acc_clr;
    logic  acc_step;
    logic  trim;
    logic  mul;
    logic  scale;
    logic  out_ld;
    wait_t wait_on;
    jmp_t  jmp;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic in_fire;
    logic out_busy;
    logic simple;
    logic more;
  } seq_stat_t;

  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w = '0;
    unique case (pc)
      UPC_FETCH: begin
        w.in_take = 1'b1;
        w.wait_on = WAIT_IN;
      end
      UPC_DISPATCH: begin
        w.simple_ld = 1'b1;
        w.jmp       = JMP_SIMPLE;
        w.target    = UPC_OUT;
      end
      UPC_WRITE: begin
        w.hist_wr = 1'b1;
        w.acc_clr = 1'b1;
      end
      UPC_READ: begin
        w.acc_step = 1'b1;
        w.jmp      = JMP_MORE;
        w.target   = UPC_READ;
      end
      UPC_TRIM:  w.trim  = 1'b1;
      UPC_MUL:   w.mul   = 1'b1;
      UPC_SCALE: w.scale = 1'b1;
      UPC_OUT: begin
        w.out_ld  = 1'b1;
        w.wait_on = WAIT_OUT;
        w.jmp     = JMP_ALWAYS;
        w.target  = UPC_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

/* sv/mss_in_if.sv */
// Sample input channel: valid/ready with mux, channel and raw sample.
interface mss_in_if;
  import mss_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [IN_MUX_W-1:0]    mux_index;
  logic [IN_CHAN_W-1:0]   channel_index;
  logic [IN_SAMPLE_W-1:0] sample;

  modport source (output valid, mux_index, channel_index, sample, input ready);
  modport sink   (input valid, mux_index, channel_index, sample, output ready);
endinterface

/* sv/mss_out_if.sv */
// Result channel: valid/ready with the smoothed value.
interface mss_out_if;
  import mss_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [OUT_VALUE_W-1:0] smoothed_value;

  modport source (output valid, smoothed_value, input ready);
  modport sink   (input valid, smoothed_value, output ready);
endinterface

/* sv/mss_cfg_if.sv */
// Configuration write channel: valid/ready with register index and data.
interface mss_cfg_if;
  import mss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/mss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mss_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 416,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/mss_seq.sv */
// Microcode sequencer: step counter, control ROM, wait and jump logic.
module mss_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  mss_pkg::seq_stat_t stat,
  output mss_pkg::uword_t    ctl
);
  import mss_pkg::*;

  upc_t pc_r, pc_nxt;
  logic hold;
  logic take;

  assign ctl = ucode(pc_r);

  always_comb begin
    unique case (ctl.wait_on)
      WAIT_NONE: hold = 1'b0;
      WAIT_IN:   hold = !stat.in_fire;
      WAIT_OUT:  hold = stat.out_busy;
      default:   hold = 1'b0;
    endcase

    unique case (ctl.jmp)
      JMP_NEVER:  take = 1'b0;
      JMP_ALWAYS: take = 1'b1;
      JMP_SIMPLE: take = stat.simple;
      JMP_MORE:   take = stat.more;
      default:    take = 1'b0;
    endcase

    priority if (hold) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = ctl.target;
    end else begin
      pc_nxt = upc_t'(pc_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UPC_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* sv/mux_sensor_smoother.sv */
// Sensor smoother top level: trimmed mean over a 13-deep history per channel.
// One item at a time; a trimmed-mean item is held by the history read loop, which reads
// every window entry in turn through the single RAM read port.
// Passthrough, half-weight, button and out-of-range items go from dispatch straight to output.
// The result becomes valid when the output step fires; output stalls hold the sequencer there.
// Sync reset clears mode, mask, slots, fill flags and last results; unwritten history reads 0.
module mux_sensor_smoother #(
  parameter int NUM_MUX     = 4,
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 10
) (
  input logic       clk,
  input logic       rst_n,
  mss_in_if.sink    in_ch,
  mss_out_if.source out_ch,
  mss_cfg_if.sink   cfg_ch
);
  import mss_pkg::*;

  localparam int SLOTS  = NUM_MUX * CHANNELS;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HW     = (SAMPLE_BITS < IN_SAMPLE_W) ? SAMPLE_BITS : IN_SAMPLE_W;
  localparam int SUM_W  = HW + $clog2(WINDOW);
  localparam int DEPTH  = SLOTS * WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = SUM_W + DIV_MUL_W;

  uword_t    ctl;
  seq_stat_t stat;

  // configuration
  logic [MODE_W-1:0] mode_r;
  logic [BTN_W-1:0]  mask_r;

  // latched item
  logic [IN_MUX_W-1:0]  mux_r;
  logic [IN_CHAN_W-1:0] chan_r;
  logic [HW-1:0]        samp_r;

  // per-channel state
  logic [SLOT_W-1:0] slot_r [SLOTS];
  logic              full_r [SLOTS];
  logic [HW-1:0]     last_r [SLOTS];

  // datapath
  logic [PTR_W-1:0]       ptr_r, ptr_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [HW-1:0]          min_r, min_nxt;
  logic [HW-1:0]          max_r, max_nxt;
  logic [SUM_W-1:0]       trim_r;
  logic [PROD_W-1:0]      prod_r;
  logic [HW-1:0]          res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_VALUE_W-1:0] out_val_r;

  logic                in_fire;
  logic                out_fire;
  logic                rng;
  logic [IDX_W-1:0]    idx;
  logic                btn;
  logic                avg;
  logic                half;
  logic [HW:0]         half_sum;
  logic [SLOT_W:0]     slot_inc;
  logic [SLOT_W-1:0]   slot_new;
  logic [SLOT_W-1:0]   rd_ent;
  logic                ent_ok;
  logic [HW-1:0]       ent_val;
  logic                rd_en;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr;
  logic [HW-1:0]       rd_data;

  assign cfg_ch.ready      = 1'b1;
  assign in_ch.ready       = ctl.in_take;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.smoothed_value = out_val_r;

  assign in_fire  = in_ch.valid && ctl.in_take;
  assign out_fire = ctl.out_ld && !stat.out_busy;

  assign stat.in_fire  = in_fire;
  assign stat.out_busy = out_valid_r && !out_ch.ready;
  assign stat.simple   = !avg;
  assign stat.more     = 32'(ptr_r) != WINDOW;

  mss_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  // address decode of the held item
  assign rng  = (32'(mux_r) < NUM_MUX) && (32'(chan_r) < CHANNELS);
  assign idx  = IDX_W'(32'(mux_r) * CHANNELS + 32'(chan_r));
  assign btn  = mask_r[mux_r];
  assign avg  = rng && !btn && (mode_r == MODE_TRIM);
  assign half = rng && !btn && (mode_r == MODE_HALF);
  assign half_sum = {1'b0, samp_r} + {1'b0, last_r[idx]};

  // write slot advances before the write, wrapping at the window length
  assign slot_inc = {1'b0, slot_r[idx]} + 1'b1;
  assign slot_new = (32'(slot_inc) >= WINDOW) ? '0 : slot_inc[SLOT_W-1:0];
  assign waddr    = ADDR_W'(32'(idx) * WINDOW + 32'(slot_new));

  // read loop: issue entry ptr, consume entry ptr-1
  assign rd_en   = ctl.acc_step && (32'(ptr_r) < WINDOW);
  assign raddr   = ADDR_W'(32'(idx) * WINDOW + 32'(ptr_r));
  assign rd_ent  = SLOT_W'(ptr_r - 1'b1);
  assign ent_ok  = full_r[idx] || ((rd_ent != '0) && (rd_ent <= slot_r[idx]));
  assign ent_val = ent_ok ? rd_data : '0;

  mss_ram #(
    .WIDTH (HW),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ctl.hist_wr),
    .waddr (waddr),
    .wdata (samp_r),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_comb begin
    ptr_nxt = ptr_r;
    sum_nxt = sum_r;
    min_nxt = min_r;
    max_nxt = max_r;
    res_nxt = res_r;

    if (ctl.acc_clr) begin
      ptr_nxt = '0;
      sum_nxt = '0;
      min_nxt = '1;
      max_nxt = '0;
    end
    if (ctl.acc_step) begin
      if (rd_en) begin
        ptr_nxt = PTR_W'(ptr_r + 1'b1);
      end
      if (ptr_r != '0) begin
        sum_nxt = sum_r + SUM_W'(ent_val);
        min_nxt = (ent_val < min_r) ? ent_val : min_r;
        max_nxt = (ent_val > max_r) ? ent_val : max_r;
      end
    end

    if (ctl.simple_ld) begin
      res_nxt = half ? half_sum[HW:1] : samp_r;
    end else if (ctl.scale) begin
      res_nxt = prod_r[DIV_SHIFT +: HW];
    end

    if (out_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_PASS;
      mask_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_r[i] <= '0;
        full_r[i] <= 1'b0;
        last_r[i] <= '0;
      end
    end else begin
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        if (cfg_ch.index == REG_SMOOTH_MODE) begin
          mode_r <= cfg_ch.data[MODE_W-1:0];
        end else if (cfg_ch.index == REG_BUTTON_MASK) begin
          mask_r <= cfg_ch.data[BTN_W-1:0];
        end
      end
      if (ctl.hist_wr) begin
        slot_r[idx] <= slot_new;
        if (slot_new == '0) begin
          full_r[idx] <= 1'b1;
        end
      end
      if (out_fire && rng) begin
        last_r[idx] <= res_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mux_r  <= in_ch.mux_index;
      chan_r <= in_ch.channel_index;
      samp_r <= in_ch.sample[HW-1:0];
    end
    sum_r <= sum_nxt;
    min_r <= min_nxt;
    max_r <= max_nxt;
    res_r <= res_nxt;
    if (ctl.trim) begin
      trim_r <= sum_r - SUM_W'(min_r) - SUM_W'(max_r);
    end
    if (ctl.mul) begin
      prod_r <= PROD_W'(trim_r) * PROD_W'(DIV_MUL);
    end
    if (out_fire) begin
      out_val_r <= OUT_VALUE_W'(res_r);
    end
  end

`ifndef SYNTH
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("second item taken while one is in flight");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ptr_r) <= WINDOW)
    else $error("history read pointer past window");

  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.scale |=> (res_r >= min_r) && (res_r <= max_r))
    else $error("trimmed mean outside window min/max");

  a_last_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && rng) |=> (last_r[idx] == res_r))
    else $error("last result not recorded for channel");
`endif

endmodule
